[src/xfcc_pkg.sv]
// ============================================================================
// xfcc_pkg - shared types and constants for the XTEA feedback chain cipher
// Holds the word type, configuration register indexes and cipher constants.
// ============================================================================
package xfcc_pkg;

    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_cfg_index;

    // configuration register indexes
    localparam t_cfg_index CFG_KEY_WORD_0  = 3'd0;
    localparam t_cfg_index CFG_KEY_WORD_1  = 3'd1;
    localparam t_cfg_index CFG_KEY_WORD_2  = 3'd2;
    localparam t_cfg_index CFG_KEY_WORD_3  = 3'd3;
    localparam t_cfg_index CFG_ROUND_COUNT = 3'd4;
    localparam t_cfg_index CFG_DIRECTION   = 3'd5;

    localparam int    ROUND_COUNT_W     = 7;
    localparam logic [ROUND_COUNT_W-1:0] ROUND_COUNT_RESET = 7'd32;

    localparam t_word XTEA_DELTA = 32'h9e37_79b9;
    localparam int    PAD_W      = 3;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

endpackage

[src/xtea_feedback_chain_cipher_top.sv]
// ============================================================================
// xtea_feedback_chain_cipher_top - XTEA with interleaved feedback chaining
// One 64-bit block per request, encrypted or decrypted over a configurable
// number of double rounds by a single shared half-round unit.
// ============================================================================
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | i_valid / o_ready  | block_low, block_high, first_block, last_block
//  output  | o_valid / i_ready  | result_low, result_high, pad_length, tail_zero
//  config  | i_cfg_we           | i_cfg_index, i_cfg_wdata (no read-back)
//
//  Sequencing: one half round per cycle; a block's n double rounds
//  (n = round_count, capped at MAX_ROUNDS) run as pairs of half rounds in
//  the shared half-round unit, then the finish state; o_ready is high only
//  when idle, so the next block waits until the last one leaves finish.
//  Reset: synchronous, active low; clears chaining state, control and config.
//  Stalls: a finished result waits in the output register; a new request is
//  taken meanwhile, and its result waits in the finish state until the output
//  register frees up.
//
module xtea_feedback_chain_cipher_top #(
    parameter int MAX_ROUNDS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  xfcc_pkg::t_cfg_index  i_cfg_index,
    input  xfcc_pkg::t_word       i_cfg_wdata,

    // input requests
    input  logic                  i_valid,
    output logic                  o_ready,
    input  xfcc_pkg::t_word       i_block_low,
    input  xfcc_pkg::t_word       i_block_high,
    input  logic                  i_first_block,
    input  logic                  i_last_block,

    // result requests
    output logic                  o_valid,
    input  logic                  i_ready,
    output xfcc_pkg::t_word       o_result_low,
    output xfcc_pkg::t_word       o_result_high,
    output logic [2:0]            o_pad_length,
    output logic                  o_tail_zero
);
    import xfcc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } t_state;

    // configuration registers
    t_word                    r_key [4];
    logic [ROUND_COUNT_W-1:0] r_round_count;
    logic                     r_direction;

    // chaining state
    logic [63:0]              r_prev_cipher;
    logic [63:0]              r_prev_plain;

    // sequencer and working registers
    t_state                   r_state;
    logic [CNT_W-1:0]         r_left;      // double rounds still to run
    logic                     r_phase;     // 0 first half round, 1 second
    t_word                    r_y;
    t_word                    r_z;
    t_word                    r_sum;
    logic [63:0]              r_blk;       // block as received, for chaining
    logic                     r_first;
    logic                     r_last;

    // output register
    logic                     r_valid;
    t_word                    r_res_low;
    t_word                    r_res_high;
    logic [PAD_W-1:0]         r_pad;
    logic                     r_tail;

    // ------------------------------------------------------------------
    // Effective round count, capped at MAX_ROUNDS
    // ------------------------------------------------------------------
    logic             rc_over;
    logic [CNT_W-1:0] n_rounds;
    t_word            n_sum_init;

    assign rc_over  = (32'(r_round_count) > 32'(MAX_ROUNDS));
    assign n_rounds = rc_over ? CNT_W'(MAX_ROUNDS) : CNT_W'(r_round_count);

    // decrypt starts from delta * n, encrypt from zero
    assign n_sum_init = (r_direction == DIR_DECRYPT) ? 32'(XTEA_DELTA * 32'(n_rounds))
                                                     : '0;

    // ------------------------------------------------------------------
    // Input chaining: encrypt folds in prev cipher, decrypt prev plain
    // ------------------------------------------------------------------
    logic [63:0] in_blk;
    logic [63:0] in_chain;

    assign in_blk   = {i_block_high, i_block_low};
    assign in_chain = i_first_block ? in_blk
                    : in_blk ^ ((r_direction == DIR_DECRYPT) ? r_prev_plain
                                                             : r_prev_cipher);

    // ------------------------------------------------------------------
    // Shared half-round unit.
    // Encrypt: phase 0 updates y from z with key[sum&3], phase 1 updates z
    // from y with key[sum>>11]. Decrypt swaps the roles, so the target is
    // z whenever phase and direction differ.
    // ------------------------------------------------------------------
    logic       tgt_z;
    t_word      mix_in;
    t_word      target;
    logic [1:0] key_idx;
    t_word      mixed;
    t_word      f_val;
    t_word      n_target;
    t_word      n_sum_step;

    assign tgt_z    = r_phase ^ r_direction;
    assign mix_in   = tgt_z ? r_y : r_z;
    assign target   = tgt_z ? r_z : r_y;
    assign key_idx  = tgt_z ? r_sum[12:11] : r_sum[1:0];
    assign mixed    = ((mix_in << 4) ^ (mix_in >> 5)) + mix_in;
    assign f_val    = mixed ^ (r_sum + r_key[key_idx]);
    assign n_target = (r_direction == DIR_DECRYPT) ? target - f_val : target + f_val;
    assign n_sum_step = (r_direction == DIR_DECRYPT) ? r_sum - XTEA_DELTA
                                                     : r_sum + XTEA_DELTA;

    // ------------------------------------------------------------------
    // Output chaining and flags
    // ------------------------------------------------------------------
    logic [63:0] core_res;
    logic [63:0] n_res;
    logic        n_tail;
    logic        out_free;

    assign core_res = {r_z, r_y};
    assign n_res    = r_first ? core_res
                    : core_res ^ ((r_direction == DIR_DECRYPT) ? r_prev_cipher
                                                               : r_prev_plain);
    assign n_tail   = r_last && (n_res[31:8] == '0) && (n_res[63:32] == '0);
    assign out_free = !r_valid || i_ready;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]      <= '0;
            r_key[1]      <= '0;
            r_key[2]      <= '0;
            r_key[3]      <= '0;
            r_round_count <= ROUND_COUNT_RESET;
            r_direction   <= DIR_ENCRYPT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD_0:  r_key[0]      <= i_cfg_wdata;
                CFG_KEY_WORD_1:  r_key[1]      <= i_cfg_wdata;
                CFG_KEY_WORD_2:  r_key[2]      <= i_cfg_wdata;
                CFG_KEY_WORD_3:  r_key[3]      <= i_cfg_wdata;
                CFG_ROUND_COUNT: r_round_count <= i_cfg_wdata[ROUND_COUNT_W-1:0];
                CFG_DIRECTION:   r_direction   <= i_cfg_wdata[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, datapath and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_phase       <= 1'b0;
            r_left        <= '0;
            r_prev_cipher <= '0;
            r_prev_plain  <= '0;
        end else begin
            // the finish state reloads the output register itself
            if (r_valid && i_ready && (r_state != S_FINISH)) begin
                r_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_y     <= in_chain[31:0];
                        r_z     <= in_chain[63:32];
                        r_sum   <= n_sum_init;
                        r_blk   <= in_blk;
                        r_first <= i_first_block;
                        r_last  <= i_last_block;
                        r_left  <= n_rounds;
                        r_phase <= 1'b0;
                        // zero rounds: straight to the chaining output
                        r_state <= (n_rounds == '0) ? S_FINISH : S_RUN;
                    end
                end
                S_RUN: begin
                    if (tgt_z) begin
                        r_z <= n_target;
                    end else begin
                        r_y <= n_target;
                    end
                    if (!r_phase) begin
                        r_sum   <= n_sum_step;
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_left  <= r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_valid    <= 1'b1;
                        r_res_low  <= n_res[31:0];
                        r_res_high <= n_res[63:32];
                        r_pad      <= n_res[PAD_W-1:0];
                        r_tail     <= n_tail;
                        if (r_direction == DIR_DECRYPT) begin
                            r_prev_cipher <= r_blk;
                            r_prev_plain  <= n_res;
                        end else begin
                            r_prev_cipher <= n_res;
                            r_prev_plain  <= r_blk;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_valid;
    assign o_result_low  = r_res_low;
    assign o_result_high = r_res_high;
    assign o_pad_length  = r_pad;
    assign o_tail_zero   = r_tail;

`ifndef SYNTHESIS
    // an accepted request always takes the block out of the ready state
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted but block still ready");

    // the round counter never runs past the cap, and is live while running
    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_left != '0 && 32'(r_left) <= 32'(MAX_ROUNDS)))
        else $error("round counter out of range while running");

    // a waiting result is never overwritten by the finish state
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_res_low) && $stable(r_res_high)))
        else $error("pending result lost or changed");

    // a run ends after its second half round only
    a_finish_on_phase1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_phase == 1'b0) |=> (r_state == S_RUN))
        else $error("run left mid double round");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for xtea_feedback_chain_cipher_top
// Feeds 64-bit blocks through the request channel with random gaps and result
// back-pressure. Every accepted block is run through an in-bench XTEA chaining
// predictor and each result is checked field by field, in order. Settings
// change between phases, only while the cipher is empty.
// ============================================================================
module tb_top;

    import xfcc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int MAX_ROUNDS    = 64;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int LONG_STALL    = 400;               // > two slowest blocks
    localparam int DRAIN_CYCLES  = 2 * MAX_ROUNDS + 16;
    localparam int TIMEOUT_NS    = 10_000_000;         // watchdog limit, in ns

    typedef struct packed {
        t_word lo;
        t_word hi;
        logic  first;
        logic  last;
    } t_block_req;

    typedef struct packed {
        t_word      lo;
        t_word      hi;
        logic [2:0] pad;
        logic       tail;
    } t_result;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    t_cfg_index i_cfg_index   = CFG_KEY_WORD_0;
    t_word      i_cfg_wdata   = '0;
    logic       i_valid       = 1'b0;
    t_word      i_block_low   = '0;
    t_word      i_block_high  = '0;
    logic       i_first_block = 1'b0;
    logic       i_last_block  = 1'b0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    t_word      o_result_low;
    t_word      o_result_high;
    logic [2:0] o_pad_length;
    logic       o_tail_zero;

    xtea_feedback_chain_cipher_top #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .i_first_block(i_first_block),
        .i_last_block (i_last_block),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_low (o_result_low),
        .o_result_high(o_result_high),
        .o_pad_length (o_pad_length),
        .o_tail_zero  (o_tail_zero)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: shadow of the config registers and the chaining words
    // ------------------------------------------------------------------------
    t_word       cfg_key [4] = '{default: '0};
    logic [6:0]  cfg_rounds  = ROUND_COUNT_RESET;
    logic        cfg_dir     = DIR_ENCRYPT;
    logic [63:0] chain_cipher = '0;
    logic [63:0] chain_plain  = '0;

    t_block_req pending_blocks[$];     // requests not yet offered
    t_result    expected_results[$];   // results owed by the cipher, oldest first

    // bookkeeping
    int  reqs_issued     = 0;
    int  reqs_accepted   = 0;
    int  results_seen    = 0;
    int  tail_hits       = 0;
    int  fail_count      = 0;
    int  settings_used   = 0;
    bit  tx_idle_on      = 1'b1;
    bit  rx_idle_on      = 1'b1;
    bit  long_stall_done = 1'b0;
    int  tx_gap          = 0;
    int  rx_stall        = 0;

    // ------------------------------------------------------------------------
    // XTEA core of the predictor
    // ------------------------------------------------------------------------
    function automatic t_word xtea_mix(input t_word w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // round_count above the cap saturates; zero means pass-through
    function automatic int active_rounds();
        return (cfg_rounds > MAX_ROUNDS) ? MAX_ROUNDS : int'(cfg_rounds);
    endfunction

    function automatic logic [63:0] xtea_encipher(input logic [63:0] blk, input int n);
        t_word y;
        t_word z;
        t_word sum;
        y   = blk[31:0];
        z   = blk[63:32];
        sum = '0;
        for (int i = 0; i < n; i++) begin
            y   = y + (xtea_mix(z) ^ (sum + cfg_key[sum[1:0]]));
            sum = sum + XTEA_DELTA;
            z   = z + (xtea_mix(y) ^ (sum + cfg_key[sum[12:11]]));
        end
        return {z, y};
    endfunction

    function automatic logic [63:0] xtea_decipher(input logic [63:0] blk, input int n);
        t_word y;
        t_word z;
        t_word sum;
        y   = blk[31:0];
        z   = blk[63:32];
        sum = XTEA_DELTA * t_word'(n);
        for (int i = 0; i < n; i++) begin
            z   = z - (xtea_mix(y) ^ (sum + cfg_key[sum[12:11]]));
            sum = sum - XTEA_DELTA;
            y   = y - (xtea_mix(z) ^ (sum + cfg_key[sum[1:0]]));
        end
        return {z, y};
    endfunction

    // Result of one accepted block; advances the chaining words.
    // Encrypt: E(P ^ prevC) ^ prevP, decrypt: D(C ^ prevP) ^ prevC,
    // first block of a message skips the feedback.
    function automatic t_result predict_block(input t_block_req req);
        logic [63:0] blk;
        logic [63:0] res;
        t_result     r;
        int          n;
        blk = {req.hi, req.lo};
        n   = active_rounds();
        if (cfg_dir == DIR_ENCRYPT) begin
            res = req.first ? xtea_encipher(blk, n)
                            : xtea_encipher(blk ^ chain_cipher, n) ^ chain_plain;
            chain_cipher = res;
            chain_plain  = blk;
        end else begin
            res = req.first ? xtea_decipher(blk, n)
                            : xtea_decipher(blk ^ chain_plain, n) ^ chain_cipher;
            chain_cipher = blk;
            chain_plain  = res;
        end
        r.lo   = res[31:0];
        r.hi   = res[63:32];
        r.pad  = res[2:0];
        r.tail = req.last && (res[63:8] == '0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: changes inputs on the falling edge. A request stays up,
    // payload frozen, until reqs_accepted catches up with reqs_issued.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : request_driver
        t_block_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && (reqs_accepted != reqs_issued)) begin
            // still waiting for o_ready
        end else if (tx_gap != 0) begin
            tx_gap--;
            i_valid <= 1'b0;
        end else if (pending_blocks.size() != 0 && tx_idle_on
                     && $urandom_range(0, 4) == 0) begin
            tx_gap = $urandom_range(1, 12) - 1;
            i_valid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
            req = pending_blocks.pop_front();
            i_block_low   <= req.lo;
            i_block_high  <= req.hi;
            i_first_block <= req.first;
            i_last_block  <= req.last;
            i_valid       <= 1'b1;
            reqs_issued++;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Accepted request: predict its result right away, in accept order.
    always @(posedge i_clk) begin : request_capture
        t_block_req req;
        if (i_rst_n && i_valid && o_ready) begin
            req.lo    = i_block_low;
            req.hi    = i_block_high;
            req.first = i_first_block;
            req.last  = i_last_block;
            expected_results.push_back(predict_block(req));
            reqs_accepted++;
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure. Short random stalls, plus one long hold-off
    // once plenty of requests are queued, so the cipher fills both its output
    // register and its finish state and has to drop o_ready.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_ready
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else if (!long_stall_done && results_seen >= 150
                     && pending_blocks.size() > 20) begin
            long_stall_done = 1'b1;
            rx_stall = LONG_STALL - 1;
            i_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall = $urandom_range(1, 12) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0d ns: %s mismatch, expected %h, got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Result monitor: sampled on the rising edge, compared with the oldest
    // outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0d ns: result %h_%h arrived with nothing expected, expected none",
                         $time, o_result_high, o_result_low);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_low",  want.lo,   o_result_low);
                check_field("result_high", want.hi,   o_result_high);
                check_field("pad_length",  want.pad,  o_pad_length);
                check_field("tail_zero",   want.tail, o_tail_zero);
                if (want.tail)
                    tail_hits++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Cipher is empty: nothing queued, no request up, no result owed.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_blocks.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_word data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx) inside
            CFG_KEY_WORD_0, CFG_KEY_WORD_1,
            CFG_KEY_WORD_2, CFG_KEY_WORD_3: cfg_key[idx[1:0]] = data;
            CFG_ROUND_COUNT:                cfg_rounds = data[6:0];
            CFG_DIRECTION:                  cfg_dir    = data[0];
            default: ;
        endcase
    endtask

    // Writes all six registers; unused upper bits of the narrow ones get noise.
    task automatic configure(input t_word k0, input t_word k1, input t_word k2,
                             input t_word k3, input logic [6:0] rounds, input logic dir);
        t_word rw;
        t_word dw;
        wait_idle();
        rw      = $urandom();
        rw[6:0] = rounds;
        dw      = $urandom();
        dw[0]   = dir;
        write_reg(CFG_KEY_WORD_0, k0);
        write_reg(CFG_KEY_WORD_1, k1);
        write_reg(CFG_KEY_WORD_2, k2);
        write_reg(CFG_KEY_WORD_3, k3);
        write_reg(CFG_ROUND_COUNT, rw);
        write_reg(CFG_DIRECTION, dw);
        settings_used++;
    endtask

    task automatic push_block(input t_word lo, input t_word hi, input logic first,
                              input logic last);
        t_block_req req;
        req.lo    = lo;
        req.hi    = hi;
        req.first = first;
        req.last  = last;
        pending_blocks.push_back(req);
    endtask

    // One message of len blocks. Well-formed: first/last flags in place and,
    // mostly, a padded final block (bytes 1..7 zero). When decrypting, the
    // plaintext is chain-encrypted here first so the cipher recovers it,
    // which exercises the zero-tail flag. Otherwise: raw noise.
    task automatic queue_message(input int len, input bit well_formed);
        logic [63:0] plain;
        logic [63:0] blk;
        logic [63:0] pc;
        logic [63:0] pp;
        int          n;
        int          b;
        n  = active_rounds();
        pc = '0;
        pp = '0;
        for (b = 0; b < len; b++) begin
            if (!well_formed) begin
                push_block($urandom(), $urandom(), 1'($urandom()), 1'($urandom()));
            end else begin
                plain = {$urandom(), $urandom()};
                if (b == len - 1 && $urandom_range(0, 3) != 0)
                    plain[63:8] = '0;
                if (cfg_dir == DIR_DECRYPT) begin
                    blk = (b == 0) ? xtea_encipher(plain, n)
                                   : xtea_encipher(plain ^ pc, n) ^ pp;
                    pc  = blk;
                    pp  = plain;
                end else begin
                    blk = plain;
                end
                push_block(blk[31:0], blk[63:32], b == 0, b == len - 1);
            end
        end
    endtask

    function automatic t_word random_key_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly short round counts keep the run fast; zero, the default, the
    // cap and values beyond the cap show up now and then.
    function automatic logic [6:0] random_rounds();
        case ($urandom_range(0, 9))
            6:       return 7'd0;
            7:       return 7'd32;
            8:       return 7'(MAX_ROUNDS);
            9:       return 7'($urandom_range(MAX_ROUNDS + 1, 127));
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int random_sent;
        int target;
        int len;
        int phase;
        random_sent = 0;
        phase       = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: a chained block before any message start (zero
        // feedback), then all-ones and a mid-message last block
        push_block('0, '0, 1'b0, 1'b0);
        push_block('1, '1, 1'b1, 1'b0);
        push_block(32'h1234_5678, 32'h9abc_def0, 1'b0, 1'b1);

        // zero rounds: only the feedback XORs act, so zero tails are easy
        configure('1, '1, '1, '1, 7'd0, DIR_ENCRYPT);
        push_block(32'h0000_00a5, '0, 1'b1, 1'b1);
        push_block(32'h0000_0100, '0, 1'b0, 1'b1);
        push_block(32'h0000_00fe, '0, 1'b0, 1'b1);
        push_block('1, '1, 1'b0, 1'b0);

        // all-ones round count saturates to the cap; decrypt a real message
        configure($urandom(), $urandom(), $urandom(), $urandom(), 7'd127, DIR_DECRYPT);
        queue_message(3, 1'b1);

        // direction flipped mid-message: chaining carries on from stored words
        configure($urandom(), $urandom(), $urandom(), $urandom(), 7'd1, DIR_ENCRYPT);
        push_block($urandom(), $urandom(), 1'b0, 1'b0);
        push_block($urandom(), $urandom(), 1'b0, 1'b1);

        // one past the cap, zero key
        configure('0, '0, '0, '0, 7'(MAX_ROUNDS + 1), DIR_ENCRYPT);
        queue_message(2, 1'b1);

        // full cap, all-ones key, decrypt
        configure('1, '1, '1, '1, 7'(MAX_ROUNDS), DIR_DECRYPT);
        queue_message(2, 1'b1);

        // random phases; every fourth one runs without idling, and so does
        // the tail end of the run
        while (random_sent < RANDOM_ITEMS) begin
            configure(random_key_word(), random_key_word(), random_key_word(),
                      random_key_word(), random_rounds(), 1'($urandom()));
            tx_idle_on = (phase % 4 != 2) && (random_sent < RANDOM_ITEMS - 150);
            rx_idle_on = tx_idle_on;
            target = random_sent + $urandom_range(60, 140);
            while (random_sent < target) begin
                len = $urandom_range(1, 6);
                queue_message(len, $urandom_range(0, 6) != 0);
                random_sent += len;
            end
            phase++;
        end

        wait_idle();
        // any stray result after the last one would be flagged by the monitor
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d blocks in %0d settings, %0d results checked, %0d zero tails",
                 reqs_accepted, settings_used, results_seen, tail_hits);
        $display("summary: long result stall %s, %0d mismatches",
                 long_stall_done ? "done" : "not reached", fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout at %0d ns with %0d results outstanding",
                 $time, expected_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule

[xtea_feedback_chain_cipher_top.f]
src/xfcc_pkg.sv
src/xtea_feedback_chain_cipher_top.sv
tb/tb_top.sv
